### design/rbtl_pkg.sv
// Shared types and constants for the ring buffer time lookup block.
// Used by rbtl_front, rbtl_back and ring_buffer_time_lookup_core.
package rbtl_pkg;

    // Default store depth, handed down from the top level
    localparam int ENTRIES_DEFAULT = 16;

    // Transfer queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Field widths
    localparam int STAMP_W = 32;
    localparam int VALUE_W = 32;

    // Not-found answer: -1.0 in Q16.16
    localparam logic signed [VALUE_W-1:0] NOT_FOUND_VALUE = 32'shFFFF_0000;

    // Item kinds
    typedef enum logic
    {
        KIND_ADD    = 1'b0,
        KIND_LOOKUP = 1'b1
    } kind_t;

    // One accepted input item
    typedef struct packed
    {
        kind_t                      kind;
        logic [STAMP_W-1:0]         stamp;
        logic signed [VALUE_W-1:0]  sample;
    } item_t;

    // Queue head as seen by the back end
    typedef struct packed
    {
        logic   valid;
        item_t  item;
    } queue_head_t;

    // Back end sequencer states
    typedef enum logic [2:0]
    {
        B_IDLE,
        B_RD_MID,
        B_RD_LO,
        B_RD_HI,
        B_DECIDE,
        B_VALUE
    } back_state_t;

endpackage

### design/ring_buffer_time_lookup_core.sv
// Top level of the ring buffer time lookup block.
// Depends on rbtl_pkg, rbtl_front, rbtl_back (and rbtl_ram below it).
//
//  channel   handshake        payload                    note
//  -------   --------------   ------------------------   ---------------------------
//  item in   start / busy     kind, stamp, sample        transfer when start & !busy
//  result    done (strobe)    found, result_value        one cycle, cannot be held
//
// An add is written to the store as it leaves the queue and gives no result. A lookup
// leaves the queue in B_IDLE, then runs each probe that misses through B_RD_MID,
// B_RD_LO, B_RD_HI and B_DECIDE (mid, low and high stamp reads through the single
// read port of the stamp RAM, then the bound update), up to clog2(ENTRIES)+1 probes.
// A matching probe ends after the mid read with B_VALUE; a miss ends with the bound
// check in B_RD_MID. The strobe is registered and rises in the cycle after either
// end, and a lookup may first wait behind older items in the queue.
// After reset the store reads as cleared (stamp 0, value 0) through the write
// pointer and a wrap flag; no clearing pass is needed. busy rises only when
// the two-entry input queue is full; results are never stalled.
module ring_buffer_time_lookup_core
    import rbtl_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       kind,
    input  logic [STAMP_W-1:0]         stamp,
    input  logic signed [VALUE_W-1:0]  sample,
    output logic                       done,
    output logic                       found,
    output logic signed [VALUE_W-1:0]  result_value
);

    item_t        item_in;
    queue_head_t  head;
    logic         pop;

    // Pack the command fields into one item
    always_comb
    begin
        item_in.kind   = kind_t'(kind);
        item_in.stamp  = stamp;
        item_in.sample = sample;
    end

    rbtl_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item_in (item_in),
        .head    (head),
        .pop     (pop)
    );

    rbtl_back #(.ENTRIES(ENTRIES)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .done         (done),
        .found        (found),
        .result_value (result_value)
    );

endmodule

### design/rbtl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rbtl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  waddr,
    input  logic [WIDTH-1:0]          wdata,
    input  logic [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/rbtl_front.sv
// Front end: takes items on the command port and holds them in a short queue.
// Depends on rbtl_pkg.
module rbtl_front
    import rbtl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  item_t        item_in,
    output queue_head_t  head,
    input  logic         pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push;
    logic           do_pop;

    assign busy   = (count_reg == CW'(QUEUE_DEPTH));
    assign push   = start && !busy;
    assign do_pop = pop && (count_reg != '0);

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

endmodule

### design/rbtl_back.sv
// Back end: applies adds to the ring store and runs the rotated binary search.
// Depends on rbtl_pkg and rbtl_ram.
module rbtl_back
    import rbtl_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  queue_head_t                head,
    output logic                       pop,
    output logic                       done,
    output logic                       found,
    output logic signed [VALUE_W-1:0]  result_value
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IW = AW + 2;   // signed index, spans -1 .. ENTRIES
    localparam logic signed [IW-1:0] IDX_ONE  = IW'(1);
    localparam logic signed [IW-1:0] IDX_LAST = IW'(ENTRIES - 1);

    back_state_t                 state_reg, state_next;
    logic signed [IW-1:0]        lo_reg, lo_next;
    logic signed [IW-1:0]        hi_reg, hi_next;
    logic [STAMP_W-1:0]          key_reg, key_next;
    logic [STAMP_W-1:0]          s_mid_reg, s_mid_next;
    logic [STAMP_W-1:0]          s_lo_reg, s_lo_next;
    logic [AW-1:0]               write_slot_reg, write_slot_next;
    logic                        wrapped_reg, wrapped_next;
    logic [AW-1:0]               rd_addr_reg;
    logic                        done_reg, done_next;
    logic                        found_reg, found_next;
    logic signed [VALUE_W-1:0]   value_reg, value_next;

    logic signed [IW-1:0]        mid;
    logic [AW-1:0]               mid_addr;
    logic [AW-1:0]               stamp_raddr;
    logic                        ram_we;
    logic [STAMP_W-1:0]          stamp_rdata;
    logic [VALUE_W-1:0]          value_rdata;
    logic [STAMP_W-1:0]          stamp_eff;
    logic                        mid_live;

    // A slot holds written data once the ring has wrapped or the slot is below
    // the write pointer; otherwise it still reads as cleared.
    function automatic logic slot_live(input logic [AW-1:0] idx,
                                       input logic [AW-1:0] ws,
                                       input logic          wr);
        return wr || (idx < ws);
    endfunction

    assign mid      = lo_reg + ((hi_reg - lo_reg) >>> 1);
    assign mid_addr = mid[AW-1:0];
    assign mid_live = slot_live(mid_addr, write_slot_reg, wrapped_reg);
    assign stamp_eff = slot_live(rd_addr_reg, write_slot_reg, wrapped_reg) ?
                       stamp_rdata : '0;
    assign ram_we   = (state_reg == B_IDLE) && head.valid && (head.item.kind == KIND_ADD);

    // Stamp and value stores
    rbtl_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_slot_reg),
        .wdata (head.item.stamp),
        .raddr (stamp_raddr),
        .rdata (stamp_rdata)
    );

    rbtl_ram #(.WIDTH(VALUE_W), .DEPTH(ENTRIES)) u_value_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (write_slot_reg),
        .wdata (head.item.sample),
        .raddr (mid_addr),
        .rdata (value_rdata)
    );

    // Next state: sequencer and search bounds
    always_comb
    begin
        state_next      = state_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        key_next        = key_reg;
        s_mid_next      = s_mid_reg;
        s_lo_next       = s_lo_reg;
        write_slot_next = write_slot_reg;
        wrapped_next    = wrapped_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.item.kind == KIND_ADD)
                    begin
                        if (write_slot_reg == AW'(ENTRIES - 1))
                        begin
                            write_slot_next = '0;
                            wrapped_next    = 1'b1;
                        end
                        else
                        begin
                            write_slot_next = write_slot_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        key_next   = head.item.stamp;
                        lo_next    = '0;
                        hi_next    = IDX_LAST;
                        state_next = B_RD_MID;
                    end
                end
            end
            B_RD_MID:
            begin
                state_next = (lo_reg > hi_reg) ? B_IDLE : B_RD_LO;
            end
            B_RD_LO:
            begin
                if (stamp_eff == key_reg)
                begin
                    state_next = B_VALUE;
                end
                else
                begin
                    s_mid_next = stamp_eff;
                    state_next = B_RD_HI;
                end
            end
            B_RD_HI:
            begin
                s_lo_next  = stamp_eff;
                state_next = B_DECIDE;
            end
            B_DECIDE:
            begin
                // stamp_eff holds the high-end stamp here
                if (s_lo_reg <= s_mid_reg)
                begin
                    if (key_reg >= s_lo_reg && key_reg < s_mid_reg)
                        hi_next = mid - IDX_ONE;
                    else
                        lo_next = mid + IDX_ONE;
                end
                else
                begin
                    if (key_reg > s_mid_reg && key_reg <= stamp_eff)
                        lo_next = mid + IDX_ONE;
                    else
                        hi_next = mid - IDX_ONE;
                end
                state_next = B_RD_MID;
            end
            B_VALUE:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Outputs: queue pop, read address, result strobe
    always_comb
    begin
        pop         = 1'b0;
        stamp_raddr = mid_addr;
        done_next   = 1'b0;
        found_next  = 1'b0;
        value_next  = NOT_FOUND_VALUE;
        unique case (state_reg)
            B_IDLE:
            begin
                pop = head.valid;
            end
            B_RD_MID:
            begin
                stamp_raddr = mid_addr;
                if (lo_reg > hi_reg)
                begin
                    done_next = 1'b1;
                end
            end
            B_RD_LO:
            begin
                stamp_raddr = lo_reg[AW-1:0];
            end
            B_RD_HI:
            begin
                stamp_raddr = hi_reg[AW-1:0];
            end
            B_DECIDE:
            begin
                stamp_raddr = mid_addr;
            end
            B_VALUE:
            begin
                done_next  = 1'b1;
                found_next = 1'b1;
                value_next = mid_live ? value_rdata : '0;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            lo_reg         <= '0;
            hi_reg         <= '0;
            write_slot_reg <= '0;
            wrapped_reg    <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            write_slot_reg <= write_slot_next;
            wrapped_reg    <= wrapped_next;
            done_reg       <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        s_mid_reg   <= s_mid_next;
        s_lo_reg    <= s_lo_next;
        rd_addr_reg <= stamp_raddr;
        found_reg   <= found_next;
        value_reg   <= value_next;
    end

    assign done         = done_reg;
    assign found        = found_reg;
    assign result_value = value_reg;

    // Checks
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !found_reg) |-> (value_reg == NOT_FOUND_VALUE))
        else $error("miss without the not-found value");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        write_slot_reg <= AW'(ENTRIES - 1))
        else $error("write slot out of range");

    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_RD_LO) |-> (lo_reg >= 0 && hi_reg <= IDX_LAST))
        else $error("probe bounds outside the store");

endmodule
